@@ src/ewmv_pkg.sv @@
// Package for the exponentially weighted mean, variance and covariance unit.
// Holds the payload structs, register constants, item kind codes and the
// multiplier request and response types. No dependencies.
package ewmv_pkg;

  localparam int unsigned ALPHA_W   = 17;
  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned MEAN_W    = 40;
  localparam int unsigned VAR_W     = 63;
  localparam int unsigned COV_W     = 64;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned OPND_W    = 64;
  localparam int unsigned PROD_W    = 2 * OPND_W;

  localparam logic [ALPHA_W-1:0] ALPHA_MIN   = 17'd66;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        IDX_ALPHA  = 1'b0;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_PAIR   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]                 kind;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
  } in_item_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic signed [COV_W-1:0]  covariance;
    logic                     seeded;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [OPND_W-1:0] op_a;
    logic [OPND_W-1:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage

@@ src/ewmv_mul.sv @@
// Shared multi-cycle 64 x 64 multiplier built from one 32 x 32 multiplier.
// Four partial products are formed in turn and accumulated.
// Depends on ewmv_pkg.
module ewmv_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ewmv_pkg::mul_req_t req_i,
  output ewmv_pkg::mul_rsp_t rsp_o
);

  localparam int unsigned CHUNK_W  = ewmv_pkg::OPND_W / 2;
  localparam logic [2:0]  LAST_CNT = 3'd4;

  logic                            busy_q, busy_d;
  logic [2:0]                      cnt_q, cnt_d;
  logic                            done_q, done_d;
  logic [ewmv_pkg::OPND_W-1:0]     a_q, a_d, b_q, b_d;
  logic [ewmv_pkg::OPND_W-1:0]     pp_q, pp_d;
  logic [ewmv_pkg::PROD_W-1:0]     acc_q, acc_d;
  logic [CHUNK_W-1:0]              a_chunk, b_chunk;
  logic [ewmv_pkg::PROD_W-1:0]     pp_sh;

  always_comb begin
    a_chunk = cnt_q[1] ? a_q[ewmv_pkg::OPND_W-1:CHUNK_W] : a_q[CHUNK_W-1:0];
    b_chunk = cnt_q[0] ? b_q[ewmv_pkg::OPND_W-1:CHUNK_W] : b_q[CHUNK_W-1:0];
    pp_d    = a_chunk * b_chunk;
    unique case (cnt_q)
      3'd1:       pp_sh = {{ewmv_pkg::OPND_W{1'b0}}, pp_q};
      3'd2, 3'd3: pp_sh = {{CHUNK_W{1'b0}}, pp_q, {CHUNK_W{1'b0}}};
      LAST_CNT:   pp_sh = {pp_q, {ewmv_pkg::OPND_W{1'b0}}};
      default:    pp_sh = '0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = busy_q && (cnt_q == LAST_CNT);
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = req_i.op_a;
      b_d    = req_i.op_b;
      acc_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 3'd1;
      acc_d = acc_q + pp_sh;
      if (cnt_q == LAST_CNT) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    pp_q  <= pp_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

@@ src/ewmv_cfg.sv @@
// APB-style register port holding the smoothing weight alpha.
// Clamps written values to the legal range. Depends on ewmv_pkg.
module ewmv_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ewmv_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ewmv_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ewmv_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [ewmv_pkg::ALPHA_W-1:0]        alpha_o
);

  logic [ewmv_pkg::ALPHA_W-1:0] alpha_q, alpha_d;
  logic [ewmv_pkg::ALPHA_W-1:0] wr_val;
  logic                         wr_en;
  logic                         idx;

  assign pready = 1'b1;
  assign idx    = paddr[ewmv_pkg::CFG_ADDR_W-1];
  assign wr_en  = psel && penable && pwrite && pready && (idx == ewmv_pkg::IDX_ALPHA);
  assign wr_val = pwdata[ewmv_pkg::ALPHA_W-1:0];

  always_comb begin
    alpha_d = alpha_q;
    if (wr_en) begin
      priority if (wr_val < ewmv_pkg::ALPHA_MIN) begin
        alpha_d = ewmv_pkg::ALPHA_MIN;
      end else if (wr_val > ewmv_pkg::ALPHA_ONE) begin
        alpha_d = ewmv_pkg::ALPHA_ONE;
      end else begin
        alpha_d = wr_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ewmv_pkg::ALPHA_RESET;
    end else begin
      alpha_q <= alpha_d;
    end
  end

  assign prdata  = (idx == ewmv_pkg::IDX_ALPHA) ?
                   ewmv_pkg::CFG_DATA_W'(alpha_q) : '0;
  assign alpha_o = alpha_q;

endmodule

@@ src/ewmv_seq.sv @@
// Sequencer and state of the weighted mean, variance and covariance update.
// Drives the shared multiplier through each item's steps and owns the
// output register. Depends on ewmv_pkg.
module ewmv_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ewmv_pkg::ALPHA_W-1:0]  alpha_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ewmv_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ewmv_pkg::out_item_t           out_data_o,
  output ewmv_pkg::mul_req_t            mul_req_o,
  input  ewmv_pkg::mul_rsp_t            mul_rsp_i
);

  localparam int unsigned MW = ewmv_pkg::MEAN_W;
  localparam int unsigned VW = ewmv_pkg::VAR_W;
  localparam int unsigned CW = ewmv_pkg::COV_W;
  localparam int unsigned FW = ewmv_pkg::FRAC_W;
  localparam int unsigned DW = MW + 1;
  localparam int unsigned QW = DW + FW;
  localparam int unsigned SH = 2 * FW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  localparam logic [2:0] OP_AX    = 3'd0;
  localparam logic [2:0] OP_AY    = 3'd1;
  localparam logic [2:0] OP_QXX   = 3'd2;
  localparam logic [2:0] OP_QXY   = 3'd3;
  localparam logic [2:0] OP_DECAY = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [2:0]              op_q, op_d;
  logic                    started_q, started_d;
  logic                    seeded_q, seeded_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [MW-1:0]    avg_q, avg_d, mx_q, mx_d, my_q, my_d;
  logic [VW-1:0]           spread_q, spread_d;
  logic signed [CW-1:0]    co_q, co_d;

  logic [1:0]              kind_q, kind_d;
  logic signed [MW-1:0]    x_q, x_d, y_q, y_d;
  logic [DW-1:0]           magx_q, magx_d, magy_q, magy_d;
  logic                    negx_q, negx_d, negy_q, negy_d;
  logic [QW-1:0]           qx_q, qx_d, qy_q, qy_d;
  logic signed [CW-1:0]    s_q, s_d;
  ewmv_pkg::out_item_t     out_q, out_d;

  logic signed [MW-1:0]    refx;
  logic signed [DW-1:0]    xe, ye, rxe, rye;
  logic                    geq_x, geq_y;
  logic [ewmv_pkg::PROD_W-1:0] prod;
  logic [VW-1:0]           t;
  logic [CW-1:0]           var_sum, var_s;
  logic [CW:0]             co65, t65, cov_r;
  logic signed [CW-1:0]    cov_s;
  logic [VW-1:0]           m;
  logic [CW-1:0]           m64, abs_s;
  logic [DW-1:0]           stepx, stepy, avg41, mx41, my41, avg_new, mx_new, my_new;
  logic [ewmv_pkg::ALPHA_W-1:0] oma;

  // Deltas and their magnitudes against the means before update.
  always_comb begin
    refx   = (kind_q == ewmv_pkg::KIND_PAIR) ? mx_q : avg_q;
    xe     = {x_q[MW-1], x_q};
    ye     = {y_q[MW-1], y_q};
    rxe    = {refx[MW-1], refx};
    rye    = {my_q[MW-1], my_q};
    geq_x  = (x_q >= refx);
    geq_y  = (y_q >= my_q);
    magx_d = geq_x ? DW'(xe - rxe) : DW'(rxe - xe);
    magy_d = geq_y ? DW'(ye - rye) : DW'(rye - ye);
    negx_d = !geq_x;
    negy_d = !geq_y;
  end

  // Post-processing of the multiplier result.
  always_comb begin
    prod    = mul_rsp_i.product;
    t       = (|prod[ewmv_pkg::PROD_W-1:VW+SH]) ? {VW{1'b1}} : prod[VW+SH-1:SH];
    var_sum = {1'b0, spread_q} + {1'b0, t};
    var_s   = var_sum[CW-1] ? {1'b0, {VW{1'b1}}} : var_sum;
    co65    = {co_q[CW-1], co_q};
    t65     = {2'b00, t};
    cov_r   = (negx_q ^ negy_q) ? (co65 - t65) : (co65 + t65);
    priority if (cov_r[CW] != cov_r[CW-1]) begin
      cov_s = cov_r[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      cov_s = cov_r[CW-1:0];
    end
    m       = prod[VW+FW-1:FW];
    m64     = {1'b0, m};
    stepx   = qx_q[QW-1:FW];
    stepy   = qy_q[QW-1:FW];
    avg41   = {avg_q[MW-1], avg_q};
    mx41    = {mx_q[MW-1], mx_q};
    my41    = {my_q[MW-1], my_q};
    avg_new = negx_q ? (avg41 - stepx) : (avg41 + stepx);
    mx_new  = negx_q ? (mx41 - stepx) : (mx41 + stepx);
    my_new  = negy_q ? (my41 - stepy) : (my41 + stepy);
    abs_s   = s_q[CW-1] ? (CW'(0) - s_q) : s_q;
    oma     = ewmv_pkg::ALPHA_ONE - alpha_i;
  end

  // Multiplier operand select.
  always_comb begin
    mul_req_o.start = (state_q == S_ISSUE);
    unique case (op_q)
      OP_AX: begin
        mul_req_o.op_a = ewmv_pkg::OPND_W'(alpha_i);
        mul_req_o.op_b = ewmv_pkg::OPND_W'(magx_q);
      end
      OP_AY: begin
        mul_req_o.op_a = ewmv_pkg::OPND_W'(alpha_i);
        mul_req_o.op_b = ewmv_pkg::OPND_W'(magy_q);
      end
      OP_QXX: begin
        mul_req_o.op_a = ewmv_pkg::OPND_W'(qx_q);
        mul_req_o.op_b = ewmv_pkg::OPND_W'(magx_q);
      end
      OP_QXY: begin
        mul_req_o.op_a = ewmv_pkg::OPND_W'(qx_q);
        mul_req_o.op_b = ewmv_pkg::OPND_W'(magy_q);
      end
      OP_DECAY: begin
        mul_req_o.op_a = abs_s;
        mul_req_o.op_b = ewmv_pkg::OPND_W'(oma);
      end
      default: begin
        mul_req_o.op_a = '0;
        mul_req_o.op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    started_d   = started_q;
    seeded_d    = seeded_q;
    out_valid_d = out_valid_q && out_stall_i;
    avg_d       = avg_q;
    mx_d        = mx_q;
    my_d        = my_q;
    spread_d    = spread_q;
    co_d        = co_q;
    kind_d      = kind_q;
    x_d         = x_q;
    y_d         = y_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    s_d         = s_q;
    out_d       = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d   = in_data_i.kind;
          x_d      = {in_data_i.sample_x, {FW{1'b0}}};
          y_d      = {in_data_i.sample_y, {FW{1'b0}}};
          seeded_d = 1'b0;
          state_d  = S_PREP;
        end
      end
      S_PREP: begin
        state_d = S_WRITE;
        op_d    = OP_AX;
        unique case (kind_q)
          ewmv_pkg::KIND_CLEAR: begin
            avg_d     = '0;
            mx_d      = '0;
            my_d      = '0;
            spread_d  = '0;
            co_d      = '0;
            started_d = 1'b0;
          end
          ewmv_pkg::KIND_SINGLE: begin
            if (!started_q) begin
              avg_d     = x_q;
              spread_d  = '0;
              started_d = 1'b1;
              seeded_d  = 1'b1;
            end else begin
              state_d = S_ISSUE;
            end
          end
          ewmv_pkg::KIND_PAIR: begin
            if (!started_q) begin
              mx_d      = x_q;
              my_d      = y_q;
              co_d      = '0;
              started_d = 1'b1;
              seeded_d  = 1'b1;
            end else begin
              state_d = S_ISSUE;
            end
          end
          default: begin
            state_d = S_WRITE;
          end
        endcase
      end
      S_ISSUE: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mul_rsp_i.done) begin
          state_d = S_ISSUE;
          unique case (op_q)
            OP_AX: begin
              qx_d = prod[QW-1:0];
              op_d = (kind_q == ewmv_pkg::KIND_PAIR) ? OP_AY : OP_QXX;
            end
            OP_AY: begin
              qy_d = prod[QW-1:0];
              op_d = OP_QXY;
            end
            OP_QXX: begin
              s_d  = var_s;
              op_d = OP_DECAY;
            end
            OP_QXY: begin
              s_d  = cov_s;
              op_d = OP_DECAY;
            end
            OP_DECAY: begin
              state_d = S_WRITE;
              if (kind_q == ewmv_pkg::KIND_PAIR) begin
                co_d = s_q[CW-1] ? (CW'(0) - m64) : m64;
                mx_d = mx_new[MW-1:0];
                my_d = my_new[MW-1:0];
              end else begin
                spread_d = m;
                avg_d    = avg_new[MW-1:0];
              end
            end
            default: begin
              state_d = S_WRITE;
            end
          endcase
        end
      end
      S_WRITE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.mean       = avg_q;
          out_d.variance   = spread_q;
          out_d.covariance = co_q;
          out_d.seeded     = seeded_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_AX;
      started_q   <= 1'b0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
      mx_q        <= '0;
      my_q        <= '0;
      spread_q    <= '0;
      co_q        <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      started_q   <= started_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      avg_q       <= avg_d;
      mx_q        <= mx_d;
      my_q        <= my_d;
      spread_q    <= spread_d;
      co_q        <= co_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    x_q    <= x_d;
    y_q    <= y_d;
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    s_q    <= s_d;
    out_q  <= out_d;
    if (state_q == S_PREP) begin
      magx_q <= magx_d;
      magy_q <= magy_d;
      negx_q <= negx_d;
      negy_q <= negy_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/ew_mean_variance_covariance_unit.sv @@
// Exponentially weighted mean, variance and covariance unit, top level.
// Results come from the shared 32 x 32 multiplier: 3 products for a single
// update, 4 for a paired update, none for seeding, clear or unused kinds.
// The next item can be taken in the cycle after the result register loads.
// Reset: alpha to 6554, all means, spreads and the started flag to zero.
module ew_mean_variance_covariance_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ewmv_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ewmv_pkg::out_item_t               out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ewmv_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ewmv_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ewmv_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [ewmv_pkg::ALPHA_W-1:0] alpha;
  ewmv_pkg::mul_req_t           mul_req;
  ewmv_pkg::mul_rsp_t           mul_rsp;

  ewmv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .alpha_o (alpha)
  );

  ewmv_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  ewmv_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .alpha_i     (alpha),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp)
  );

endmodule

@@ src/ewmv_checker.sv @@
// Port-level checks for the weighted mean, variance and covariance unit.
// Bound to the top level. Depends on ewmv_pkg.
module ewmv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ewmv_pkg::out_item_t out_data_o
);

  // One item in flight: a transfer in blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not blocked after transfer");

  // A new result appears only when an item was being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work in flight");

  // Seeding leaves both spreads at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.seeded |->
      (out_data_o.variance == '0) && (out_data_o.covariance == '0))
    else $error("seeding result with nonzero spread");

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind ew_mean_variance_covariance_unit ewmv_checker u_checker (.*);
